FILE: design/i2cm_pkg.sv
// Package for the I2C master bit engine.
// Holds the command codes, pin-step constants and the result record type.
// No dependencies.
`default_nettype none

package i2cm_pkg;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_TX    = 3'd3,
        OP_RX    = 3'd4
    } op_t;

    localparam logic [3:0]  PH_END       = 4'd15;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
    localparam logic [15:0] DELAY_RESET  = 16'd6;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_in;
    } res_t;

endpackage

`default_nettype wire

FILE: design/i2cm_core.sv
// Bit engine state and per-tick next-state logic for the I2C master.
// Advances one tick when step_en is high. Depends on i2cm_pkg.
`default_nettype none

module i2cm_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_en,
    input  wire logic [2:0]    func,
    input  wire logic [7:0]    tx_byte,
    input  wire logic          ack_level,
    input  wire logic          sda_in,
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data,
    output i2cm_pkg::res_t     res_next
);
    import i2cm_pkg::*;

    logic [15:0] delay_reg;
    op_t         op_reg, op_next;
    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  shift_reg, shift_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_bit_reg, ack_bit_next;
    logic        ack_send_reg, ack_send_next;
    logic [7:0]  rx_last_reg, rx_last_next;
    logic        done;

    always_comb begin
        logic [15:0] d;
        logic [15:0] tick_inc;
        logic [3:0]  np;
        logic        do_enter;

        op_next       = op_reg;
        phase_next    = phase_reg;
        bit_next      = bit_reg;
        tick_next     = tick_reg;
        shift_next    = shift_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        ack_bit_next  = ack_bit_reg;
        ack_send_next = ack_send_reg;
        rx_last_next  = rx_last_reg;
        done          = 1'b0;
        do_enter      = 1'b0;
        np            = PH_END;
        d             = (delay_reg == 16'd0) ? 16'd1 : delay_reg;
        tick_inc      = tick_reg + 16'd1;

        if (op_reg == OP_IDLE) begin
            if (func inside {[OP_START:OP_RX]}) begin
                op_next    = op_t'(func);
                phase_next = 4'd0;
                bit_next   = 4'd0;
                tick_next  = 16'd0;
                if (op_t'(func) == OP_TX) begin
                    shift_next = tx_byte;
                end else if (op_t'(func) == OP_RX) begin
                    shift_next    = 8'd0;
                    ack_send_next = ack_level;
                end
                do_enter = 1'b1;
            end
        end else if (tick_inc >= d) begin
            tick_next = 16'd0;
            case (op_reg)
                OP_START, OP_STOP: begin
                    np = (phase_reg < 4'd2) ? phase_reg + 4'd1 : PH_END;
                end
                OP_TX: begin
                    if (phase_reg == 4'd2) begin
                        bit_next   = bit_reg + 4'd1;
                        shift_next = {shift_reg[6:0], 1'b0};
                        np = (bit_next < BITS_PER_BYTE) ? 4'd0 : 4'd3;
                    end else begin
                        np = (phase_reg < 4'd6) ? phase_reg + 4'd1 : PH_END;
                    end
                end
                OP_RX: begin
                    if (phase_reg == 4'd3) begin
                        bit_next = bit_reg + 4'd1;
                        np = (bit_next < BITS_PER_BYTE) ? 4'd1 : 4'd4;
                    end else begin
                        np = (phase_reg < 4'd6) ? phase_reg + 4'd1 : PH_END;
                    end
                end
                default: np = PH_END;
            endcase
            if (np == PH_END) begin
                if (op_reg == OP_RX) begin
                    rx_last_next = shift_next;
                end
                op_next    = OP_IDLE;
                phase_next = 4'd0;
                done       = 1'b1;
            end else begin
                phase_next = np;
                do_enter   = 1'b1;
            end
        end else begin
            tick_next = tick_inc;
        end

        if (do_enter) begin
            case (op_next)
                OP_START: begin
                    if (phase_next == 4'd0) begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end else if (phase_next == 4'd1) begin
                        sda_next = 1'b0;
                    end else begin
                        scl_next = 1'b0;
                    end
                end
                OP_STOP: begin
                    if (phase_next == 4'd0) begin
                        sda_next = 1'b0;
                    end else if (phase_next == 4'd1) begin
                        scl_next = 1'b1;
                    end else begin
                        sda_next = 1'b1;
                    end
                end
                OP_TX: begin
                    case (phase_next)
                        4'd0:    sda_next = shift_next[7];
                        4'd1:    scl_next = 1'b1;
                        4'd2:    scl_next = 1'b0;
                        4'd3:    sda_next = 1'b1;
                        4'd4:    scl_next = 1'b1;
                        4'd5:    ack_bit_next = sda_in;
                        default: scl_next = 1'b0;
                    endcase
                end
                OP_RX: begin
                    case (phase_next)
                        4'd0:    sda_next = 1'b1;
                        4'd1:    scl_next = 1'b1;
                        4'd2:    shift_next = {shift_next[6:0], sda_in};
                        4'd3:    scl_next = 1'b0;
                        4'd4:    sda_next = ack_send_next;
                        4'd5:    scl_next = 1'b1;
                        default: begin
                            scl_next = 1'b0;
                            sda_next = 1'b1;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res_next.scl_out  = scl_next;
        res_next.sda_out  = sda_next;
        res_next.busy_res = (op_next != OP_IDLE);
        res_next.done_res = done;
        res_next.rx_byte  = rx_last_next;
        res_next.ack_in   = ack_bit_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg    <= DELAY_RESET;
            op_reg       <= OP_IDLE;
            phase_reg    <= 4'd0;
            bit_reg      <= 4'd0;
            tick_reg     <= 16'd0;
            shift_reg    <= 8'd0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            ack_bit_reg  <= 1'b1;
            ack_send_reg <= 1'b0;
            rx_last_reg  <= 8'd0;
        end else begin
            if (cfg_wr_en) begin
                delay_reg <= cfg_wr_data;
            end
            if (step_en) begin
                op_reg       <= op_next;
                phase_reg    <= phase_next;
                bit_reg      <= bit_next;
                tick_reg     <= tick_next;
                shift_reg    <= shift_next;
                scl_reg      <= scl_next;
                sda_reg      <= sda_next;
                ack_bit_reg  <= ack_bit_next;
                ack_send_reg <= ack_send_next;
                rx_last_reg  <= rx_last_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/i2c_master_bit_engine_unit.sv
// I2C master bit engine, top level: tick channel in, pin/status channel out.
// Each input transaction is one timing tick carrying a command and the SDA
// line level; each tick yields exactly one output transaction with the SCL
// and SDA levels to drive, busy, a one-tick done pulse, the last received
// byte and the last sampled ACK.
// The output is registered and valid in the cycle after input acceptance.
// Throughput: one tick per cycle unless stalled; s_ready is high whenever
// the output register is empty or is being taken in the same cycle.
// If the receiver stalls (m_ready low with m_valid high), the output holds
// and s_ready drops until it is taken; the engine does not advance.
// Reset (aresetn low, synchronous) releases SCL and SDA, goes idle, sets
// delay_ticks to 6, clears the received byte and sets the ACK bit to 1.
// delay_ticks is written via cfg_wr_en/cfg_wr_data; users must do so only
// while idle (unchecked by the block). Zero acts as one tick per pin step.
// Depends on i2cm_pkg and i2cm_core.
`default_nettype none

module i2c_master_bit_engine_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [7:0]  s_tx_byte,
    input  wire logic        s_ack_level,
    input  wire logic        s_sda_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_scl_out,
    output logic             m_sda_out,
    output logic             m_busy_res,
    output logic             m_done_res,
    output logic [7:0]       m_rx_byte,
    output logic             m_ack_in
);
    import i2cm_pkg::*;

    logic  m_valid_reg;
    res_t  res_reg;
    res_t  res_next;
    logic  in_acc;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_acc  = s_valid && s_ready;

    i2cm_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (in_acc),
        .func        (s_func),
        .tx_byte     (s_tx_byte),
        .ack_level   (s_ack_level),
        .sda_in      (s_sda_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_next    (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            res_reg <= res_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_scl_out  = res_reg.scl_out;
    assign m_sda_out  = res_reg.sda_out;
    assign m_busy_res = res_reg.busy_res;
    assign m_done_res = res_reg.done_res;
    assign m_rx_byte  = res_reg.rx_byte;
    assign m_ack_in   = res_reg.ack_in;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for i2c_master_bit_engine_unit.
// Directed tick table then random ticks, checked against a local predictor
// of the bit engine. Depends on i2cm_pkg and the design sources only.
module testbench;
    import i2cm_pkg::*;

    localparam logic [2:0]  FUNC_UNUSED_LO  = 3'd5;
    localparam logic [2:0]  FUNC_UNUSED_MID = 3'd6;
    localparam logic [2:0]  FUNC_MAX        = 3'd7;
    localparam logic [15:0] DELAY_ZERO      = 16'd0;
    localparam logic [15:0] DELAY_MIN       = 16'd1;
    localparam int          HOLD_CYCLES     = 40;
    localparam int          REPORT_LIMIT    = 10;
    localparam longint      CYCLE_LIMIT     = 1_500_000;
    localparam int          NUM_ROWS        = 25;
    localparam int          FAST_ROW        = 7;

    localparam res_t IDLE_RES  = res_t'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1};
    localparam res_t START_RES = res_t'{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1};
    localparam res_t NO_RES    = '0;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  tx_byte;
        logic        ack_level;
        logic        sda_in;
        logic [15:0] ticks;
        logic        fixed_res;
        res_t        want;
    } tick_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = '0;
    logic [7:0]  s_tx_byte = '0;
    logic        s_ack_level = 1'b0;
    logic        s_sda_in = 1'b1;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_scl_out;
    logic        m_sda_out;
    logic        m_busy_res;
    logic        m_done_res;
    logic [7:0]  m_rx_byte;
    logic        m_ack_in;

    // predictor state
    op_t         eng_op;
    logic [3:0]  eng_phase;
    logic [3:0]  eng_bit;
    logic [15:0] eng_ticks;
    logic [15:0] step_len;
    logic [7:0]  eng_shift;
    logic [7:0]  last_rx;
    logic        drv_scl;
    logic        drv_sda;
    logic        last_ack;
    logic        ack_plan;

    res_t        pin_status_q [$];
    res_t        seen_res;
    res_t        wanted_res;
    tick_row_t   dir_rows [NUM_ROWS];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatch_count = 0;
    int          stall_left = 0;
    bit          hold_req = 1'b0;
    longint      cycle_count = 0;

    i2c_master_bit_engine_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_tx_byte   (s_tx_byte),
        .s_ack_level (s_ack_level),
        .s_sda_in    (s_sda_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_out   (m_scl_out),
        .m_sda_out   (m_sda_out),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_rx_byte   (m_rx_byte),
        .m_ack_in    (m_ack_in)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic void reset_engine_model();
        eng_op    = OP_IDLE;
        eng_phase = '0;
        eng_bit   = '0;
        eng_ticks = '0;
        step_len  = DELAY_RESET;
        eng_shift = '0;
        last_rx   = '0;
        drv_scl   = 1'b1;
        drv_sda   = 1'b1;
        last_ack  = 1'b1;
        ack_plan  = 1'b0;
    endfunction

    // pin action on the first tick of a step
    function automatic void apply_step(input logic sd);
        case (eng_op)
            OP_START: begin
                if (eng_phase == 4'd0) begin
                    drv_sda = 1'b1;
                    drv_scl = 1'b1;
                end else if (eng_phase == 4'd1) begin
                    drv_sda = 1'b0;
                end else begin
                    drv_scl = 1'b0;
                end
            end
            OP_STOP: begin
                if (eng_phase == 4'd0) begin
                    drv_sda = 1'b0;
                end else if (eng_phase == 4'd1) begin
                    drv_scl = 1'b1;
                end else begin
                    drv_sda = 1'b1;
                end
            end
            OP_TX: begin
                case (eng_phase)
                    4'd0: drv_sda = eng_shift[7];
                    4'd1: drv_scl = 1'b1;
                    4'd2: drv_scl = 1'b0;
                    4'd3: drv_sda = 1'b1;
                    4'd4: drv_scl = 1'b1;
                    4'd5: last_ack = sd;
                    default: drv_scl = 1'b0;
                endcase
            end
            OP_RX: begin
                case (eng_phase)
                    4'd0: drv_sda = 1'b1;
                    4'd1: drv_scl = 1'b1;
                    4'd2: eng_shift = {eng_shift[6:0], sd};
                    4'd3: drv_scl = 1'b0;
                    4'd4: drv_sda = ack_plan;
                    4'd5: drv_scl = 1'b1;
                    default: begin
                        drv_scl = 1'b0;
                        drv_sda = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic logic [3:0] following_step();
        case (eng_op)
            OP_START, OP_STOP: return (eng_phase < 4'd2) ? eng_phase + 4'd1 : PH_END;
            OP_TX: begin
                if (eng_phase == 4'd2) begin
                    eng_bit   = eng_bit + 4'd1;
                    eng_shift = eng_shift << 1;
                    return (eng_bit < BITS_PER_BYTE) ? 4'd0 : 4'd3;
                end
                return (eng_phase < 4'd6) ? eng_phase + 4'd1 : PH_END;
            end
            OP_RX: begin
                if (eng_phase == 4'd3) begin
                    eng_bit = eng_bit + 4'd1;
                    return (eng_bit < BITS_PER_BYTE) ? 4'd1 : 4'd4;
                end
                return (eng_phase < 4'd6) ? eng_phase + 4'd1 : PH_END;
            end
            default: return PH_END;
        endcase
    endfunction

    function automatic res_t predict_bus_tick(input logic [2:0] f, input logic [7:0] tb,
                                              input logic al, input logic sd);
        logic [15:0] d;
        logic [3:0]  np;
        res_t        r;
        d = (step_len == 16'd0) ? 16'd1 : step_len;
        r = NO_RES;
        if (eng_op == OP_IDLE) begin
            if (f >= OP_START && f <= OP_RX) begin
                eng_op    = op_t'(f);
                eng_phase = '0;
                eng_bit   = '0;
                eng_ticks = '0;
                if (f == OP_TX) begin
                    eng_shift = tb;
                end else if (f == OP_RX) begin
                    eng_shift = '0;
                    ack_plan  = al;
                end
                apply_step(sd);
            end
        end else begin
            eng_ticks = eng_ticks + 16'd1;
            if (eng_ticks >= d) begin
                eng_ticks = '0;
                np = following_step();
                if (np == PH_END) begin
                    if (eng_op == OP_RX) last_rx = eng_shift;
                    eng_op     = OP_IDLE;
                    eng_phase  = '0;
                    r.done_res = 1'b1;
                end else begin
                    eng_phase = np;
                    apply_step(sd);
                end
            end
        end
        r.scl_out  = drv_scl;
        r.sda_out  = drv_sda;
        r.busy_res = (eng_op != OP_IDLE);
        r.rx_byte  = last_rx;
        r.ack_in   = last_ack;
        return r;
    endfunction

    function automatic logic [2:0] random_func();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60) return OP_IDLE;
        if (pick < 92) return 3'($urandom_range(OP_RX, OP_START));
        return 3'($urandom_range(FUNC_MAX, FUNC_UNUSED_LO));
    endfunction

    task automatic drive_tick(input logic [2:0] f, input logic [7:0] tb, input logic al,
                              input logic sd, input logic use_fixed, input res_t fixed);
        res_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= f;
        s_tx_byte   <= tb;
        s_ack_level <= al;
        s_sda_in    <= sd;
        do @(posedge aclk); while (!s_ready);
        pred = predict_bus_tick(f, tb, al, sd);
        pin_status_q.push_back(use_fixed ? fixed : pred);
    endtask

    task automatic drive_random_tick(input logic [2:0] f);
        drive_tick(f, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'b0, NO_RES);
    endtask

    // tick on until the engine is idle, then wait for every output transaction
    task automatic settle_engine();
        while (eng_op != OP_IDLE) drive_random_tick(OP_IDLE);
        s_valid <= 1'b0;
        while (pin_status_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_step_len(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        step_len = v;
    endtask

    task automatic run_random_ticks(input int n, input bit with_pressure);
        for (int i = 0; i < n; i++) begin
            if (with_pressure && i == 60) hold_req = 1'b1;
            if (with_pressure && i == 150) begin
                s_valid <= 1'b0;
                while (pin_status_q.size() != 0) @(posedge aclk);
            end
            drive_random_tick(random_func());
        end
    endtask

    // output side: check each transaction, then choose next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_res = res_t'{m_scl_out, m_sda_out, m_busy_res, m_done_res,
                              m_rx_byte, m_ack_in};
            if (pin_status_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected output transaction: %p", seen_res);
            end else begin
                wanted_res = pin_status_q.pop_front();
                if (seen_res.scl_out !== wanted_res.scl_out ||
                    seen_res.sda_out !== wanted_res.sda_out ||
                    seen_res.busy_res !== wanted_res.busy_res ||
                    seen_res.done_res !== wanted_res.done_res ||
                    seen_res.rx_byte !== wanted_res.rx_byte ||
                    seen_res.ack_in !== wanted_res.ack_in) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $write("mismatch: exp scl=%b sda=%b busy=%b done=%b rx=%h ack=%b,",
                               wanted_res.scl_out, wanted_res.sda_out,
                               wanted_res.busy_res, wanted_res.done_res,
                               wanted_res.rx_byte, wanted_res.ack_in);
                        $display(" got scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                                 seen_res.scl_out, seen_res.sda_out, seen_res.busy_res,
                                 seen_res.done_res, seen_res.rx_byte, seen_res.ack_in);
                    end
                end
            end
        end
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        // func, tx, ack, sda, ticks, fixed, expected
        dir_rows = '{
            '{OP_IDLE,         8'h00, 1'b0, 1'b0, 16'd1,   1'b1, IDLE_RES},
            '{FUNC_UNUSED_LO,  8'hFF, 1'b1, 1'b1, 16'd1,   1'b1, IDLE_RES},
            '{FUNC_UNUSED_MID, 8'h00, 1'b0, 1'b1, 16'd1,   1'b1, IDLE_RES},
            '{FUNC_MAX,        8'hFF, 1'b1, 1'b0, 16'd1,   1'b1, IDLE_RES},
            '{OP_START,        8'h00, 1'b0, 1'b1, 16'd1,   1'b1, START_RES},
            '{OP_STOP,         8'h00, 1'b0, 1'b1, 16'd17,  1'b0, NO_RES},
            '{OP_RX,           8'h00, 1'b0, 1'b1, 16'd1,   1'b0, NO_RES},
            '{OP_TX,           8'hFF, 1'b0, 1'b0, 16'd1,   1'b0, NO_RES},
            '{OP_IDLE,         8'h00, 1'b0, 1'b0, 16'd30,  1'b0, NO_RES},
            '{OP_TX,           8'h00, 1'b1, 1'b1, 16'd1,   1'b0, NO_RES},
            '{OP_IDLE,         8'h00, 1'b0, 1'b1, 16'd30,  1'b0, NO_RES},
            '{OP_TX,           8'hA5, 1'b0, 1'b0, 16'd1,   1'b0, NO_RES},
            '{OP_TX,           8'h5A, 1'b1, 1'b1, 16'd10,  1'b0, NO_RES},
            '{OP_IDLE,         8'h00, 1'b0, 1'b0, 16'd20,  1'b0, NO_RES},
            '{OP_RX,           8'h00, 1'b0, 1'b1, 16'd1,   1'b0, NO_RES},
            '{OP_IDLE,         8'h00, 1'b0, 1'b1, 16'd30,  1'b0, NO_RES},
            '{OP_RX,           8'hFF, 1'b1, 1'b0, 16'd1,   1'b0, NO_RES},
            '{OP_IDLE,         8'h00, 1'b0, 1'b0, 16'd30,  1'b0, NO_RES},
            '{OP_RX,           8'h00, 1'b0, 1'b1, 16'd1,   1'b0, NO_RES},
            '{OP_IDLE,         8'h00, 1'b0, 1'b0, 16'd10,  1'b0, NO_RES},
            '{OP_IDLE,         8'h00, 1'b0, 1'b1, 16'd20,  1'b0, NO_RES},
            '{OP_STOP,         8'h00, 1'b0, 1'b1, 16'd1,   1'b0, NO_RES},
            '{OP_IDLE,         8'h00, 1'b0, 1'b1, 16'd5,   1'b0, NO_RES},
            '{OP_START,        8'h00, 1'b0, 1'b1, 16'd1,   1'b0, NO_RES},
            '{OP_IDLE,         8'h00, 1'b0, 1'b1, 16'd5,   1'b0, NO_RES}
        };
        reset_engine_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles more lightly than the receiver
        send_idle_pct = 36;
        recv_idle_pct = 59;
        foreach (dir_rows[r]) begin
            // from FAST_ROW on, byte transfers run at the shortest step
            if (r == FAST_ROW) begin
                settle_engine();
                write_step_len(DELAY_MIN);
            end
            for (int k = 0; k < dir_rows[r].ticks; k++) begin
                drive_tick(dir_rows[r].func, dir_rows[r].tx_byte, dir_rows[r].ack_level,
                           dir_rows[r].sda_in, dir_rows[r].fixed_res && k == 0,
                           dir_rows[r].want);
            end
        end
        settle_engine();
        write_step_len(DELAY_ZERO);
        run_random_ticks(140, 1'b0);
        settle_engine();

        send_idle_pct = 59;
        recv_idle_pct = 36;
        write_step_len(DELAY_MIN);
        run_random_ticks(140, 1'b0);
        settle_engine();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_step_len(16'd3);
        run_random_ticks(170, 1'b1);
        settle_engine();

        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
